[rtl/program_stream_packetizer_defines.svh]
// ----------------------------------------------------------------------------
// program stream packetizer assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef PROGRAM_STREAM_PACKETIZER_DEFINES_SVH
`define PROGRAM_STREAM_PACKETIZER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define PSP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("psp check failed: same-cycle rule");

// consequent must hold in the cycle after the antecedent
`define PSP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("psp check failed: next-cycle rule");

`endif

[rtl/psp_pkg.sv]
// ----------------------------------------------------------------------------
// psp_pkg
// types, constants and header builders of the program stream packetizer
// ----------------------------------------------------------------------------
`default_nettype none

package psp_pkg;

	localparam int FRAME_SIZE_BITS = 24;
	localparam logic [FRAME_SIZE_BITS-1:0] MAX_PES_PAYLOAD = FRAME_SIZE_BITS'(60000);

	localparam int HDR_BYTES    = 14;   // pack header and pes header
	localparam int SYSMAP_BYTES = 42;
	localparam int IDX_W        = 6;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	localparam logic [7:0]  STREAM_ID_VIDEO = 8'hE0;
	localparam logic [7:0]  STREAM_ID_AUDIO = 8'hC0;
	localparam logic [21:0] MUX_RATE        = 22'd2000;

	localparam logic [7:0] VIDEO_TYPE_RST = 8'd27;
	localparam logic [7:0] AUDIO_TYPE_RST = 8'd144;

	// configuration register indexes
	localparam logic REG_VIDEO_TYPE = 1'b0;
	localparam logic REG_AUDIO_TYPE = 1'b1;

	// input item kinds
	localparam logic KIND_START   = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	typedef enum logic [1:0] {
		JOB_PACK,
		JOB_PACK_SYS,
		JOB_PES_BYTE,
		JOB_BYTE
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [31:0] pts;
		logic        audio;
		logic [15:0] len16;
		logic        ovf;
		logic [7:0]  data;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [35:0] time_field(input logic [31:0] t);
		return {1'b0, t[31:30], 1'b1, t[29:15], 1'b1, t[14:0], 1'b1};
	endfunction

	function automatic logic [111:0] pack_header(input logic [31:0] t);
		return {32'h000001BA, 2'b01, time_field(t), 9'd0, 1'b1, MUX_RATE,
			1'b1, 1'b1, 5'h1F, 3'd0};
	endfunction

	function automatic logic [335:0] sys_map(input logic [7:0] vst, input logic [7:0] ast);
		return {32'h000001BB, 16'd12, 1'b1, MUX_RATE, 1'b1, 6'd1,
			1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 5'd1, 1'b0, 7'h7F,
			STREAM_ID_VIDEO, 2'd3, 1'b1, 13'd256,
			STREAM_ID_AUDIO, 2'd3, 1'b0, 13'd16,
			32'h000001BC, 16'd18, 1'b1, 2'd3, 5'd1, 7'h7F, 1'b1,
			16'd0, 16'd8,
			vst, STREAM_ID_VIDEO, 16'd0,
			ast, STREAM_ID_AUDIO, 16'd0,
			32'd0};
	endfunction

	function automatic logic [111:0] pes_header(input logic audio, input logic [15:0] len16,
			input logic [31:0] t);
		return {24'd1, (audio ? STREAM_ID_AUDIO : STREAM_ID_VIDEO), len16,
			8'h84, 8'h80, 8'h05, 4'd2, time_field(t)};
	endfunction

	// byte idx of a 14-byte header, first byte in the top bits
	function automatic logic [7:0] pick_hdr(input logic [111:0] vec, input logic [IDX_W-1:0] idx);
		logic [7:0] r;
		r = 8'd0;
		for (int i = 0; i < HDR_BYTES; i++) begin
			if (idx == IDX_W'(i)) r = vec[111 - 8*i -: 8];
		end
		return r;
	endfunction

	function automatic logic [7:0] pick_sys(input logic [335:0] vec, input logic [IDX_W-1:0] idx);
		logic [7:0] r;
		r = 8'd0;
		for (int i = 0; i < SYSMAP_BYTES; i++) begin
			if (idx == IDX_W'(i)) r = vec[335 - 8*i -: 8];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/psp_front.sv]
// ----------------------------------------------------------------------------
// psp_front
// accepts items, tracks frame and chunk counts and issues output jobs
// ----------------------------------------------------------------------------
`default_nettype none

module psp_front (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 kind,
	input  wire logic [7:0]                           data_byte,
	input  wire logic [psp_pkg::FRAME_SIZE_BITS-1:0]  frame_size,
	input  wire logic [31:0]                          pts,
	input  wire logic                                 key_frame,
	input  wire logic                                 is_audio,
	input  wire psp_pkg::q_stat_t                     qstat,
	output logic                                      push,
	output psp_pkg::job_t                             job
);

	logic                                     frame_audio_q;
	logic [31:0]                              frame_ts_q;
	logic [psp_pkg::FRAME_SIZE_BITS-1:0]      left_frame_q;
	logic [psp_pkg::FRAME_SIZE_BITS-1:0]      left_chunk_q;

	logic                                     accept;
	logic [psp_pkg::FRAME_SIZE_BITS-1:0]      chunk;
	logic [psp_pkg::FRAME_SIZE_BITS:0]        pes_len;

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;

	// video chunks are capped, audio goes out as one chunk
	assign chunk   = (!frame_audio_q && left_frame_q > psp_pkg::MAX_PES_PAYLOAD)
		? psp_pkg::MAX_PES_PAYLOAD : left_frame_q;
	assign pes_len = {1'b0, chunk} + (psp_pkg::FRAME_SIZE_BITS + 1)'(8);

	always_comb begin
		push      = 1'b0;
		job.kind  = psp_pkg::JOB_BYTE;
		job.pts   = frame_ts_q;
		job.audio = frame_audio_q;
		job.len16 = pes_len[15:0];
		job.ovf   = |pes_len[psp_pkg::FRAME_SIZE_BITS:16];
		job.data  = data_byte;
		if (accept) begin
			if (kind == psp_pkg::KIND_START) begin
				push     = (frame_size != '0) && !is_audio;
				job.kind = key_frame ? psp_pkg::JOB_PACK_SYS : psp_pkg::JOB_PACK;
				job.pts  = pts;
			end else if (left_frame_q != '0) begin
				push     = 1'b1;
				job.kind = (left_chunk_q == '0) ? psp_pkg::JOB_PES_BYTE : psp_pkg::JOB_BYTE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_audio_q <= 1'b0;
			frame_ts_q    <= '0;
			left_frame_q  <= '0;
			left_chunk_q  <= '0;
		end else if (accept) begin
			if (kind == psp_pkg::KIND_START) begin
				frame_audio_q <= is_audio;
				frame_ts_q    <= pts;
				left_frame_q  <= frame_size;
				left_chunk_q  <= '0;
			end else if (left_frame_q != '0) begin
				left_frame_q <= left_frame_q - 1'b1;
				if (left_chunk_q == '0) begin
					left_chunk_q <= chunk - 1'b1;
				end else begin
					left_chunk_q <= left_chunk_q - 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

[rtl/psp_queue.sv]
// ----------------------------------------------------------------------------
// psp_queue
// short job queue between the front and the byte emitter
// ----------------------------------------------------------------------------
`default_nettype none

module psp_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire psp_pkg::job_t push_job,
	input  wire logic          pop,
	output psp_pkg::job_t      head,
	output psp_pkg::q_stat_t   stat
);

	psp_pkg::job_t                 slots_q [psp_pkg::Q_DEPTH];
	logic [psp_pkg::Q_AW-1:0]      wr_ptr_q;
	logic [psp_pkg::Q_AW-1:0]      rd_ptr_q;
	logic [psp_pkg::Q_AW:0]        count_q;

	assign stat.full  = (count_q == (psp_pkg::Q_AW + 1)'(psp_pkg::Q_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/psp_back.sv]
// ----------------------------------------------------------------------------
// psp_back
// walks the head job byte by byte into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module psp_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire psp_pkg::job_t    head,
	input  wire psp_pkg::q_stat_t qstat,
	input  wire logic [7:0]       video_type,
	input  wire logic [7:0]       audio_type,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [7:0]            out_byte,
	output logic                  last_in_run,
	output logic                  length_overflow
);

	logic [psp_pkg::IDX_W-1:0] idx_q;
	logic                      valid_q;
	logic [7:0]                byte_q;
	logic                      last_q;
	logic                      ovf_q;

	logic                      advance;
	logic                      load;
	logic                      in_hdr;
	logic [7:0]                nxt_byte;
	logic                      nxt_last;
	logic                      nxt_ovf;

	assign advance = !valid_q || out_ready;
	assign load    = advance && !qstat.empty;
	assign pop     = load && nxt_last;
	assign in_hdr  = (idx_q < psp_pkg::IDX_W'(psp_pkg::HDR_BYTES));

	always_comb begin
		nxt_byte = head.data;
		nxt_last = 1'b1;
		nxt_ovf  = 1'b0;
		case (head.kind)
			psp_pkg::JOB_PACK: begin
				nxt_byte = psp_pkg::pick_hdr(psp_pkg::pack_header(head.pts), idx_q);
				nxt_last = (idx_q == psp_pkg::IDX_W'(psp_pkg::HDR_BYTES - 1));
			end
			psp_pkg::JOB_PACK_SYS: begin
				if (in_hdr) begin
					nxt_byte = psp_pkg::pick_hdr(psp_pkg::pack_header(head.pts), idx_q);
				end else begin
					nxt_byte = psp_pkg::pick_sys(psp_pkg::sys_map(video_type, audio_type),
						idx_q - psp_pkg::IDX_W'(psp_pkg::HDR_BYTES));
				end
				nxt_last = (idx_q ==
					psp_pkg::IDX_W'(psp_pkg::HDR_BYTES + psp_pkg::SYSMAP_BYTES - 1));
			end
			psp_pkg::JOB_PES_BYTE: begin
				// pes header bytes carry the wrap flag, the payload byte closes the run
				if (in_hdr) begin
					nxt_byte = psp_pkg::pick_hdr(
						psp_pkg::pes_header(head.audio, head.len16, head.pts), idx_q);
					nxt_ovf  = head.ovf;
				end
				nxt_last = !in_hdr;
			end
			psp_pkg::JOB_BYTE: begin
				nxt_byte = head.data;
				nxt_last = 1'b1;
			end
			default: begin
				nxt_byte = head.data;
				nxt_last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (advance) begin
			valid_q <= !qstat.empty;
			if (load) begin
				idx_q <= nxt_last ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= nxt_byte;
			last_q <= nxt_last;
			ovf_q  <= nxt_ovf;
		end
	end

	assign out_valid       = valid_q;
	assign out_byte        = byte_q;
	assign last_in_run     = last_q;
	assign length_overflow = ovf_q;

endmodule

`default_nettype wire

[rtl/program_stream_packetizer.sv]
// ----------------------------------------------------------------------------
// program_stream_packetizer
// wraps video and audio frames as an mpeg-2 program stream, one byte a beat
// ----------------------------------------------------------------------------
// Input requests on s_*: s_tuser 0 starts a frame (size, pts, key, audio flag
// in s_tdata), s_tuser 1 carries one payload byte. Output requests on m_*
// carry one stream byte each; m_tlast marks the last byte caused by one input
// request, m_tuser flags pes header bytes whose length field wrapped.
// A video frame start gives a 14-byte pack header, 56 bytes on a key frame.
// A payload byte that opens a pes chunk gives 15 bytes, any other in a frame
// gives one. Stray bytes, audio frame starts, zero-length frames give nothing.
// Output follows the input through the job queue and the output register. The
// byte emitter sends one byte per cycle while m_tready holds, so payload
// passes at one request per cycle.
// A four-entry job queue sits between the front and the emitter; the front
// keeps taking requests until it fills, so a stalled m_tready back-pressures
// s_tready only after four pending jobs.
// Reset clears the frame counters, the queue and the output valid flag, and
// loads the stream type registers with 27 (video) and 144 (audio). The user
// must write stream types through cfg_* only while the block is idle; unenforced.
// ----------------------------------------------------------------------------
`default_nettype none

module program_stream_packetizer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,   // data_byte, frame_size, pts, key_frame, is_audio
	input  wire logic        s_tuser,   // kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // out_byte
	output logic             m_tlast,
	output logic             m_tuser,   // length_overflow
	input  wire logic        cfg_we,
	input  wire logic        cfg_addr,
	input  wire logic [7:0]  cfg_data
);

	logic [7:0]       video_type_q;
	logic [7:0]       audio_type_q;

	psp_pkg::job_t    push_job;
	psp_pkg::job_t    head_job;
	psp_pkg::q_stat_t qstat;
	logic             push;
	logic             pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			video_type_q <= psp_pkg::VIDEO_TYPE_RST;
			audio_type_q <= psp_pkg::AUDIO_TYPE_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				psp_pkg::REG_VIDEO_TYPE: video_type_q <= cfg_data;
				psp_pkg::REG_AUDIO_TYPE: audio_type_q <= cfg_data;
				default: video_type_q <= video_type_q;
			endcase
		end
	end

	psp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.kind       (s_tuser),
		.data_byte  (s_tdata[7:0]),
		.frame_size (s_tdata[31:8]),
		.pts        (s_tdata[63:32]),
		.key_frame  (s_tdata[64]),
		.is_audio   (s_tdata[65]),
		.qstat      (qstat),
		.push       (push),
		.job        (push_job)
	);

	psp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head_job),
		.stat     (qstat)
	);

	psp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head_job),
		.qstat           (qstat),
		.video_type      (video_type_q),
		.audio_type      (audio_type_q),
		.pop             (pop),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_byte        (m_tdata),
		.last_in_run     (m_tlast),
		.length_overflow (m_tuser)
	);

endmodule

`default_nettype wire

[rtl/psp_checker.sv]
// ----------------------------------------------------------------------------
// psp_checker
// port-level checks of the program stream packetizer
// ----------------------------------------------------------------------------
`default_nettype none

`include "program_stream_packetizer_defines.svh"

module psp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [7:0]  m_tdata,
	input wire logic        m_tlast,
	input wire logic        m_tuser
);

	// a stalled output byte stays put
	`PSP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tlast, m_tuser}))

	// the closing byte of a run is never a flagged header byte
	`PSP_ASSERT_NOW(a_last_not_flagged, m_tvalid && m_tlast, !m_tuser)

	// input back-pressure only with output pending
	`PSP_ASSERT_NOW(a_stall_has_output, !s_tready, m_tvalid)

endmodule

bind program_stream_packetizer psp_checker u_psp_checker (.*);

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// program stream packetizer testbench
// sends frame starts and payload requests and works out every stream byte with
// its own bit-level header builder. Each output request is compared field by
// field, in order, against the bytes still owed.
// ----------------------------------------------------------------------------

module testbench;
	import psp_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int MAX_REPORTS    = 10;

	localparam logic [31:0] PACK_HDR_CODE  = 32'h000001BA;
	localparam logic [31:0] SYS_START_CODE = 32'h000001BB;
	localparam logic [31:0] MAP_START_CODE = 32'h000001BC;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic [23:0] size;
		logic [31:0] pts;
		logic        key;
		logic        audio;
	} stream_req_t;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
		logic       ovf;
	} stream_byte_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_we;
	logic        cfg_addr;
	logic [7:0]  cfg_data;

	// muxer state as the testbench sees it
	logic [7:0]  video_type;
	logic [7:0]  audio_type;
	logic        open_audio;
	logic [31:0] open_pts;
	logic [23:0] frame_left;
	logic [23:0] chunk_left;

	logic [7:0]   hdr_buf [64];
	int           hdr_pos;
	stream_byte_t expected_bytes [$];

	int req_results;
	int bad_beats;
	int tx_idle_pct;
	int rx_idle_pct;
	int stall_left;

	program_stream_packetizer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver: a long hold-off when asked, random stalls otherwise
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				m_tready = ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin : check_output
		stream_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_bytes.size() == 0) begin
				bad_beats++;
				if (bad_beats <= MAX_REPORTS)
					$display("unexpected output byte %02h last %0b ovf %0b",
						m_tdata, m_tlast, m_tuser);
			end else begin
				want = expected_bytes.pop_front();
				if (m_tdata !== want.value || m_tlast !== want.last || m_tuser !== want.ovf) begin
					bad_beats++;
					if (bad_beats <= MAX_REPORTS)
						$display("mismatch: expected %02h last %0b ovf %0b, got %02h last %0b ovf %0b",
							want.value, want.last, want.ovf, m_tdata, m_tlast, m_tuser);
				end
			end
		end
	end

	task automatic hdr_clear();
		for (int i = 0; i < 64; i++) hdr_buf[i] = 8'd0;
		hdr_pos = 0;
	endtask

	// msb-first bit writer
	task automatic hdr_put(input int nbits, input logic [63:0] v);
		for (int i = nbits - 1; i >= 0; i--) begin
			if (v[i]) hdr_buf[hdr_pos >> 3][7 - (hdr_pos % 8)] = 1'b1;
			hdr_pos++;
		end
	endtask

	// 33-bit timestamp with marker bits, top bit always zero
	task automatic hdr_time(input logic [31:0] t);
		hdr_put(3, {1'b0, t[31:30]});
		hdr_put(1, 1);
		hdr_put(15, t[29:15]);
		hdr_put(1, 1);
		hdr_put(15, t[14:0]);
		hdr_put(1, 1);
	endtask

	task automatic hdr_emit(input int nbytes, input logic ovf);
		for (int i = 0; i < nbytes; i++)
			expected_bytes.push_back('{value: hdr_buf[i], last: 1'b0, ovf: ovf});
	endtask

	task automatic predict_request(input stream_req_t r);
		int           base;
		logic [23:0]  chunk;
		logic [31:0]  pes_len;
		stream_byte_t tail;
		base = expected_bytes.size();
		if (r.kind == KIND_START) begin
			open_audio = r.audio;
			open_pts   = r.pts;
			frame_left = r.size;
			chunk_left = '0;
			if (frame_left != 0 && !open_audio) begin
				hdr_clear();
				hdr_put(32, PACK_HDR_CODE);
				hdr_put(2, 1);
				hdr_time(open_pts);
				hdr_put(9, 0);
				hdr_put(1, 1);
				hdr_put(22, MUX_RATE);
				hdr_put(2, 2'b11);
				hdr_put(5, 5'h1F);
				hdr_put(3, 0);
				hdr_emit(HDR_BYTES, 1'b0);
				if (r.key) begin
					hdr_clear();
					hdr_put(32, SYS_START_CODE);
					hdr_put(16, 12);
					hdr_put(1, 1);
					hdr_put(22, MUX_RATE);
					hdr_put(1, 1);
					hdr_put(6, 1);
					hdr_put(5, 5'b00111);
					hdr_put(5, 1);
					hdr_put(1, 0);
					hdr_put(7, 7'h7F);
					hdr_put(8, STREAM_ID_VIDEO);
					hdr_put(2, 3);
					hdr_put(1, 1);
					hdr_put(13, 256);
					hdr_put(8, STREAM_ID_AUDIO);
					hdr_put(2, 3);
					hdr_put(1, 0);
					hdr_put(13, 16);
					hdr_put(32, MAP_START_CODE);
					hdr_put(16, 18);
					hdr_put(1, 1);
					hdr_put(2, 3);
					hdr_put(5, 1);
					hdr_put(7, 7'h7F);
					hdr_put(1, 1);
					hdr_put(16, 0);
					hdr_put(16, 8);
					hdr_put(8, video_type);
					hdr_put(8, STREAM_ID_VIDEO);
					hdr_put(16, 0);
					hdr_put(8, audio_type);
					hdr_put(8, STREAM_ID_AUDIO);
					hdr_put(16, 0);
					hdr_put(32, 0);    // crc sent as zero
					hdr_emit(SYSMAP_BYTES, 1'b0);
				end
			end
		end else if (frame_left != 0) begin
			if (chunk_left == 0) begin
				// video is cut into chunks, audio never is
				chunk = frame_left;
				if (!open_audio && chunk > MAX_PES_PAYLOAD) chunk = MAX_PES_PAYLOAD;
				chunk_left = chunk;
				pes_len = 32'(chunk) + 32'd8;
				hdr_clear();
				hdr_put(24, 1);
				hdr_put(8, open_audio ? STREAM_ID_AUDIO : STREAM_ID_VIDEO);
				hdr_put(16, pes_len[15:0]);
				hdr_put(8, 8'h84);
				hdr_put(8, 8'h80);
				hdr_put(8, 8'h05);
				hdr_put(4, 2);
				hdr_time(open_pts);
				hdr_emit(HDR_BYTES, pes_len > 32'hFFFF);
			end
			expected_bytes.push_back('{value: r.data, last: 1'b0, ovf: 1'b0});
			chunk_left--;
			frame_left--;
		end
		req_results = expected_bytes.size() - base;
		if (req_results > 0) begin
			tail = expected_bytes.pop_back();
			tail.last = 1'b1;
			expected_bytes.push_back(tail);
		end
	endtask

	function automatic stream_req_t start_req(input logic [23:0] size, input logic [31:0] pts,
			input logic key, input logic audio);
		stream_req_t r;
		r = '{kind: KIND_START, data: 8'($urandom), size: size, pts: pts, key: key,
			audio: audio};
		return r;
	endfunction

	// unused fields random, the block must ignore them
	function automatic stream_req_t byte_req(input logic [7:0] value);
		stream_req_t r;
		r = '{kind: KIND_PAYLOAD, data: value, size: 24'($urandom), pts: $urandom,
			key: 1'($urandom), audio: 1'($urandom)};
		return r;
	endfunction

	task automatic send_req(input stream_req_t r);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = r.kind;
		s_tdata  = {6'd0, r.audio, r.key, r.pts, r.size, r.data};
		do @(posedge clk); while (!s_tready);
		predict_request(r);
	endtask

	task automatic write_reg(input logic addr, input logic [7:0] value);
		@(negedge clk);
		cfg_we   = 1'b1;
		cfg_addr = addr;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (addr == REG_VIDEO_TYPE)
			video_type = value;
		else
			audio_type = value;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_frame_kinds();
		send_req(start_req(24'd2, 32'hFFFF_FFFF, 1'b1, 1'b0));
		send_req(byte_req(8'h00));
		send_req(byte_req(8'hFF));
		send_req(start_req(24'd1, 32'd0, 1'b0, 1'b0));
		send_req(byte_req(8'hA5));
		// key flag on audio does nothing, header waits for the first byte
		send_req(start_req(24'd2, 32'h8000_0001, 1'b1, 1'b1));
		send_req(byte_req(8'h5A));
		send_req(byte_req(8'h3C));
	endtask

	task automatic test_empty_and_stray();
		send_req(start_req(24'd0, 32'h1234_5678, 1'b1, 1'b0));
		send_req(byte_req(8'h11));
		send_req(start_req(24'd0, 32'h0BAD_F00D, 1'b0, 1'b1));
		send_req(byte_req(8'h22));
	endtask

	task automatic test_restart_and_overflow();
		send_req(start_req(24'd5, 32'h0000_7FFF, 1'b0, 1'b0));
		send_req(byte_req(8'h81));
		// new start drops the open frame; 65528 + 8 wraps the length to zero
		send_req(start_req(24'd65528, 32'h4000_8000, 1'b0, 1'b1));
		send_req(byte_req(8'h7E));
		send_req(start_req(24'hFF_FFFF, 32'hC000_0000, 1'b1, 1'b1));
		send_req(byte_req(8'hE7));
		send_req(start_req(24'd65527, 32'h3FFF_FFFF, 1'b0, 1'b1));
		send_req(byte_req(8'h18));
		send_req(start_req(24'hFF_FFFF, 32'hAAAA_5555, 1'b1, 1'b0));
		send_req(byte_req(8'h99));
		wait_idle();
	endtask

	task automatic test_stream_types();
		write_reg(REG_VIDEO_TYPE, 8'd0);
		write_reg(REG_AUDIO_TYPE, 8'd255);
		send_req(start_req(24'd1, 32'h5555_AAAA, 1'b1, 1'b0));
		send_req(byte_req(8'h42));
		wait_idle();
		write_reg(REG_VIDEO_TYPE, 8'd255);
		write_reg(REG_AUDIO_TYPE, 8'd0);
		send_req(start_req(24'd1, 32'h0000_0001, 1'b1, 1'b0));
		send_req(byte_req(8'h24));
		wait_idle();
	endtask

	task automatic test_backpressure();
		tx_idle_pct = 0;
		stall_left  = 400;
		send_req(start_req(24'd12, $urandom, 1'b1, 1'b0));
		repeat (12) send_req(byte_req(8'($urandom)));
		// sender holds until every owed byte is out
		wait_idle();
	endtask

	task automatic test_random_traffic(input int target, input int tx, input int rx,
			input logic [7:0] vtype, input logic [7:0] atype);
		int done;
		int pick;
		int len;
		tx_idle_pct = tx;
		rx_idle_pct = rx;
		write_reg(REG_VIDEO_TYPE, vtype);
		write_reg(REG_AUDIO_TYPE, atype);
		done = 0;
		while (done < target) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				// complete frame, mostly short
				len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(6, 1);
				send_req(start_req(24'(len), $urandom, 1'($urandom), 1'($urandom)));
				done++;
				repeat (len) begin
					send_req(byte_req(8'($urandom)));
					done++;
				end
			end else if (pick < 82) begin
				// any size, left after a few bytes
				send_req(start_req(24'($urandom_range(24'hFF_FFFF, 1)), $urandom,
					1'($urandom), 1'($urandom)));
				done++;
				repeat ($urandom_range(3)) begin
					send_req(byte_req(8'($urandom)));
					done++;
				end
			end else if (pick < 90) begin
				send_req(start_req(24'd0, $urandom, 1'($urandom), 1'($urandom)));
				done++;
			end else begin
				send_req(byte_req(8'($urandom)));
				if (req_results != 0) done++;
			end
		end
		wait_idle();
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tuser     = KIND_START;
		s_tdata     = '0;
		cfg_we      = 1'b0;
		cfg_addr    = REG_VIDEO_TYPE;
		cfg_data    = '0;
		video_type  = VIDEO_TYPE_RST;
		audio_type  = AUDIO_TYPE_RST;
		open_audio  = 1'b0;
		open_pts    = '0;
		frame_left  = '0;
		chunk_left  = '0;
		hdr_pos     = 0;
		req_results = 0;
		bad_beats   = 0;
		tx_idle_pct = 26;
		rx_idle_pct = 63;
		stall_left  = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_frame_kinds();
		test_empty_and_stray();
		test_restart_and_overflow();
		test_stream_types();
		test_backpressure();
		test_random_traffic(140, 26, 63, 8'($urandom), 8'($urandom));
		test_random_traffic(140, 63, 26, 8'd255, 8'd0);
		test_random_traffic(140, 0, 0, 8'($urandom), 8'($urandom));

		wait_idle();
		if (bad_beats == 0 && expected_bytes.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[program_stream_packetizer.f]
+incdir+rtl
rtl/psp_pkg.sv
rtl/psp_front.sv
rtl/psp_queue.sv
rtl/psp_back.sv
rtl/program_stream_packetizer.sv
rtl/psp_checker.sv
dv/testbench.sv
